### sv/bfop_pkg.sv
// shared constants and types for the bounded fifo with overflow policy
package bfop_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int LIMIT_W    = 5;
   localparam int POLICY_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [POLICY_W-1:0] {
      POL_REJECT   = 2'd0,
      POL_DROP_OLD = 2'd1,
      POL_DROP_NEW = 2'd2
   } policy_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_SHIFT = 1'b1
   } state_type;

   // per-cell control: load the pushed word, or take the neighbour's word
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

### sv/bfop_if.sv
// request and response channel interfaces
interface bfop_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] push_word;

   modport source (output valid, output cmd, output push_word, input ready);
   modport sink (input valid, input cmd, input push_word, output ready);
endinterface

interface bfop_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [4:0]  queue_length;
   logic [31:0] pop_word;
   logic        was_empty;
   logic [4:0]  dropped_count;

   modport source (output valid, output accepted, output queue_length, output pop_word,
                   output was_empty, output dropped_count, input ready);
   modport sink (input valid, input accepted, input queue_length, input pop_word,
                 input was_empty, input dropped_count, output ready);
endinterface

### sv/bfop_cell.sv
// one storage cell of the queue row
module bfop_cell
   import bfop_pkg::*;
(
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [WORD_WIDTH-1:0] push_word,
   input  logic [WORD_WIDTH-1:0] next_word,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;

   // a load wins over the shift from the neighbour
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         word_ff <= push_word;
      end else if (ctl.shift) begin
         word_ff <= next_word;
      end
   end

   assign word = word_ff;

endmodule

### sv/bounded_fifo_overflow_policy.sv
// top level: bounded fifo with length limit and overflow policy
// Queue of up to 16 words held in a row of cells, oldest word in cell 0. A request
// (push, pop or length query) gives one response, registered, the cycle after it is
// taken, or for a push that evicts under drop-oldest once the eviction ends; the next
// request may be taken in the cycle that response is taken, not while it waits. A push
// that evicts n oldest words under drop-oldest moves the row's words one cell towards
// the head per cycle, appending the pushed word with the last move. Configuration
// writes are taken at any time but should only be made while the queue is idle.
module bounded_fifo_overflow_policy
   import bfop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bfop_req_if.sink              req,
   bfop_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0]    max_len_ff;
   logic [POLICY_W-1:0]   policy_ff;
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      drop_left_ff, drop_left_in;
   logic [CNT_W-1:0]      hold_n_ff, hold_n_in;
   logic [WORD_WIDTH-1:0] hold_word_ff, hold_word_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_accepted_ff, out_accepted_in;
   logic [CNT_W-1:0]      out_len_ff, out_len_in;
   logic [WORD_WIDTH-1:0] out_pop_ff, out_pop_in;
   logic                  out_empty_ff, out_empty_in;
   logic [CNT_W-1:0]      out_dropped_ff, out_dropped_in;

   logic                  take;
   logic                  limited, over, room;
   logic [CNT_W-1:0]      n_drop;
   logic [CNT_W-1:0]      survivors, survivors_held;
   logic                  row_shift, row_load;
   logic [IDX_W-1:0]      load_idx;
   logic [WORD_WIDTH-1:0] load_word;
   logic [WORD_WIDTH-1:0] words [DEPTH];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= '0;
         policy_ff  <= POL_REJECT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_LENGTH: max_len_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_POLICY:     policy_ff  <= csr_wdata[POLICY_W-1:0];
            default:        ;
         endcase
      end
   end

   // limit checks
   assign limited = (max_len_ff != '0) && (CNT_W'(max_len_ff) <= CNT_W'(DEPTH));
   assign over    = limited && (count_ff >= CNT_W'(max_len_ff));
   assign room    = count_ff < CNT_W'(DEPTH);
   assign n_drop  = count_ff - CNT_W'(max_len_ff) + CNT_W'(1);

   // words left after an eviction, now and for the held push
   assign survivors      = count_ff - n_drop;
   assign survivors_held = count_ff - hold_n_ff;

   assign req.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign take      = req.valid && req.ready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_left_ff <= drop_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // held push and response payload
   always_ff @(posedge clock) begin
      hold_n_ff       <= hold_n_in;
      hold_word_ff    <= hold_word_in;
      out_accepted_ff <= out_accepted_in;
      out_len_ff      <= out_len_in;
      out_pop_ff      <= out_pop_in;
      out_empty_ff    <= out_empty_in;
      out_dropped_ff  <= out_dropped_in;
   end

   // next state, row control and response
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      drop_left_in    = drop_left_ff;
      hold_n_in       = hold_n_ff;
      hold_word_in    = hold_word_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_accepted_in = out_accepted_ff;
      out_len_in      = out_len_ff;
      out_pop_in      = out_pop_ff;
      out_empty_in    = out_empty_ff;
      out_dropped_in  = out_dropped_ff;
      row_shift       = 1'b0;
      row_load        = 1'b0;
      load_idx        = count_ff[IDX_W-1:0];
      load_word       = req.push_word;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               out_accepted_in = 1'b0;
               out_pop_in      = '0;
               out_empty_in    = 1'b0;
               out_dropped_in  = '0;
               out_len_in      = count_ff;
               case (req.cmd)
                  CMD_PUSH: begin
                     if (over && (policy_ff == POL_DROP_OLD)) begin
                        // evict oldest words one cell per cycle
                        state_in     = ST_SHIFT;
                        drop_left_in = n_drop;
                        hold_n_in    = n_drop;
                        hold_word_in = req.push_word;
                     end else if (over && (policy_ff == POL_DROP_NEW)) begin
                        row_load        = 1'b1;
                        load_idx        = survivors[IDX_W-1:0];
                        count_in        = survivors + CNT_W'(1);
                        out_valid_in    = 1'b1;
                        out_accepted_in = 1'b1;
                        out_len_in      = count_in;
                        out_dropped_in  = n_drop;
                     end else if (!over && room) begin
                        row_load        = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        out_valid_in    = 1'b1;
                        out_accepted_in = 1'b1;
                        out_len_in      = count_in;
                     end else begin
                        out_valid_in = 1'b1;
                     end
                  end
                  CMD_POP: begin
                     out_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        out_empty_in = 1'b1;
                     end else begin
                        row_shift  = 1'b1;
                        out_pop_in = words[0];
                        count_in   = count_ff - CNT_W'(1);
                        out_len_in = count_in;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            row_shift    = 1'b1;
            drop_left_in = drop_left_ff - CNT_W'(1);
            if (drop_left_ff == CNT_W'(1)) begin
               // last move: append the held word behind the survivors
               row_load        = 1'b1;
               load_idx        = survivors_held[IDX_W-1:0];
               load_word       = hold_word_ff;
               count_in        = survivors_held + CNT_W'(1);
               state_in        = ST_IDLE;
               out_valid_in    = 1'b1;
               out_accepted_in = 1'b1;
               out_len_in      = count_in;
               out_dropped_in  = hold_n_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // row of cells, cell 0 holds the oldest word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type          ctl;
      logic [WORD_WIDTH-1:0] next_word;

      assign ctl.shift = row_shift;
      assign ctl.load  = row_load && (load_idx == IDX_W'(i));
      if (i == DEPTH - 1) begin : g_tail
         assign next_word = '0;
      end else begin : g_body
         assign next_word = words[i + 1];
      end

      bfop_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .push_word (load_word),
         .next_word (next_word),
         .word      (words[i])
      );
   end

   // response port
   assign rsp.valid         = out_valid_ff;
   assign rsp.accepted      = out_accepted_ff;
   assign rsp.queue_length  = out_len_ff;
   assign rsp.pop_word      = out_pop_ff;
   assign rsp.was_empty     = out_empty_ff;
   assign rsp.dropped_count = out_dropped_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_shift_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> !out_valid_ff)
      else $error("response pending during eviction");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (take && (req.cmd == CMD_POP) && (count_ff != '0))
         |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not lower the count");

   a_shift_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (drop_left_ff != '0))
      else $error("eviction counter ran out");

endmodule
